// ----- src/hsb_pkg.sv -----
`timescale 1ns / 1ps

package hsb_pkg;

  localparam int SEM_MAX      = 32;
  localparam int LINE_MAX     = 2;
  localparam int SEM_DEFAULT  = 32;
  localparam int LINE_DEFAULT = 2;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 5;
  localparam int MID_W  = 4;
  localparam int PID_W  = 8;
  localparam int KEY_W  = 16;
  localparam int MASK_W = 32;
  localparam int IRQ_W  = 2;

  localparam logic [OP_W-1:0] OP_TAKE        = 3'd0;
  localparam logic [OP_W-1:0] OP_FAST_TAKE   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ        = 3'd2;
  localparam logic [OP_W-1:0] OP_RELEASE     = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE_ALL = 3'd4;
  localparam logic [OP_W-1:0] OP_NOTIFY_EN   = 3'd5;
  localparam logic [OP_W-1:0] OP_NOTIFY_DIS  = 3'd6;
  localparam logic [OP_W-1:0] OP_SERVICE     = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the input item
    logic exec;     // apply the operation to the semaphore state
    logic respond;  // load the result register
  } hsb_cmd_t;

endpackage

// ----- src/hsb_ctrl.sv -----
`timescale 1ns / 1ps

module hsb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output hsb_pkg::hsb_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          cmd.respond   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted item did not move to execute");

  a_exec_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> (state_r == S_RESP))
    else $error("execute did not move to respond");

  a_resp_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && slot_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after respond");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec, cmd.respond}))
    else $error("overlapping datapath commands");

endmodule

// ----- src/hsb_datapath.sv -----
`timescale 1ns / 1ps

module hsb_datapath #(
  parameter int NUM_SEMAPHORES = hsb_pkg::SEM_DEFAULT,
  parameter int NUM_LINES      = hsb_pkg::LINE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hsb_pkg::hsb_cmd_t             cmd,
  input  logic                          cfg_valid,
  input  logic [hsb_pkg::KEY_W-1:0]     cfg_clear_key,
  input  logic [hsb_pkg::OP_W-1:0]      in_operation,
  input  logic [hsb_pkg::IDX_W-1:0]     in_sem_index,
  input  logic [hsb_pkg::MID_W-1:0]     in_master_id,
  input  logic [hsb_pkg::PID_W-1:0]     in_process_id,
  input  logic [hsb_pkg::KEY_W-1:0]     in_release_key,
  input  logic [hsb_pkg::MASK_W-1:0]    in_sem_mask,
  input  logic                          in_irq_line,
  output logic                          out_success,
  output logic                          out_locked,
  output logic [hsb_pkg::MID_W-1:0]     out_owner_master,
  output logic [hsb_pkg::PID_W-1:0]     out_owner_process,
  output logic [hsb_pkg::MASK_W-1:0]    out_masked_status,
  output logic [hsb_pkg::IRQ_W-1:0]     out_irq_out
);

  localparam int SN = NUM_SEMAPHORES;
  localparam int LN = NUM_LINES;

  // captured item
  logic [hsb_pkg::OP_W-1:0]  op_r;
  logic [hsb_pkg::IDX_W-1:0] idx_r;
  logic [hsb_pkg::MID_W-1:0] mid_r;
  logic [hsb_pkg::PID_W-1:0] pid_r;
  logic [hsb_pkg::KEY_W-1:0] key_r;
  logic [SN-1:0]             mask_r;
  logic                      line_r;

  logic [hsb_pkg::KEY_W-1:0] clear_key_r;

  // semaphore state
  logic [SN-1:0]             lock_r, lock_nxt;
  logic [hsb_pkg::MID_W-1:0] own_m_r [SN];
  logic [hsb_pkg::MID_W-1:0] own_m_nxt [SN];
  logic [hsb_pkg::PID_W-1:0] own_p_r [SN];
  logic [hsb_pkg::PID_W-1:0] own_p_nxt [SN];
  logic [SN-1:0]             en_r [LN];
  logic [SN-1:0]             en_nxt [LN];
  logic [SN-1:0]             freed_r [LN];
  logic [SN-1:0]             freed_nxt [LN];

  logic                      success_r, success_nxt;
  logic [SN-1:0]             status_r, status_nxt;

  logic                      out_success_r;
  logic                      out_locked_r;
  logic [hsb_pkg::MID_W-1:0] out_owner_master_r;
  logic [hsb_pkg::PID_W-1:0] out_owner_process_r;
  logic [hsb_pkg::MASK_W-1:0] out_masked_status_r;
  logic [hsb_pkg::IRQ_W-1:0] out_irq_out_r;

  logic                      sem_ok, line_ok, key_ok;
  logic [SN-1:0]             hit;
  logic [LN-1:0]             lsel;
  logic [hsb_pkg::PID_W-1:0] pid_take;
  logic [SN-1:0]             free_set;

  logic                      rd_lock;
  logic [hsb_pkg::MID_W-1:0] rd_m;
  logic [hsb_pkg::PID_W-1:0] rd_p;
  logic [SN-1:0]             cur_status;
  logic [LN-1:0]             irq_vec;

  assign sem_ok   = (6'(idx_r) < 6'(SN));
  assign line_ok  = (2'(line_r) < 2'(LN));
  assign key_ok   = (key_r == clear_key_r);
  assign pid_take = (op_r == hsb_pkg::OP_FAST_TAKE) ? '0 : pid_r;

  always_comb begin
    for (int i = 0; i < SN; i++) begin
      hit[i] = sem_ok && (idx_r == hsb_pkg::IDX_W'(i));
    end
    for (int l = 0; l < LN; l++) begin
      lsel[l] = line_ok && (line_r == 1'(l));
    end
  end

  // operation update
  always_comb begin
    lock_nxt    = lock_r;
    own_m_nxt   = own_m_r;
    own_p_nxt   = own_p_r;
    en_nxt      = en_r;
    freed_nxt   = freed_r;
    success_nxt = success_r;
    status_nxt  = status_r;
    free_set    = '0;
    if (cmd.exec) begin
      success_nxt = 1'b0;
      status_nxt  = '0;
      unique case (op_r)
        hsb_pkg::OP_TAKE, hsb_pkg::OP_FAST_TAKE: begin
          for (int i = 0; i < SN; i++) begin
            if (hit[i]) begin
              if (!lock_r[i]) begin
                lock_nxt[i]  = 1'b1;
                own_m_nxt[i] = mid_r;
                own_p_nxt[i] = pid_take;
                success_nxt  = 1'b1;
              end else begin
                success_nxt = (own_m_r[i] == mid_r) && (own_p_r[i] == pid_take);
              end
            end
          end
        end
        hsb_pkg::OP_READ: begin
        end
        hsb_pkg::OP_RELEASE: begin
          for (int i = 0; i < SN; i++) begin
            if (hit[i] && lock_r[i] && own_m_r[i] == mid_r && own_p_r[i] == pid_r) begin
              free_set[i] = 1'b1;
              success_nxt = 1'b1;
            end
          end
        end
        hsb_pkg::OP_RELEASE_ALL: begin
          if (key_ok) begin
            success_nxt = 1'b1;
            for (int i = 0; i < SN; i++) begin
              free_set[i] = lock_r[i] && (own_m_r[i] == mid_r);
            end
          end
        end
        hsb_pkg::OP_NOTIFY_EN: begin
          for (int l = 0; l < LN; l++) begin
            if (lsel[l]) en_nxt[l] = en_r[l] | mask_r;
          end
        end
        hsb_pkg::OP_NOTIFY_DIS: begin
          for (int l = 0; l < LN; l++) begin
            if (lsel[l]) en_nxt[l] = en_r[l] & ~mask_r;
          end
        end
        hsb_pkg::OP_SERVICE: begin
          // status is taken before the flags and enables are cleared
          for (int l = 0; l < LN; l++) begin
            if (lsel[l]) begin
              status_nxt   = freed_r[l] & en_r[l];
              en_nxt[l]    = en_r[l] & ~(freed_r[l] & en_r[l]);
              freed_nxt[l] = freed_r[l] & ~(freed_r[l] & en_r[l]);
            end
          end
        end
        default: begin
        end
      endcase
      for (int i = 0; i < SN; i++) begin
        if (free_set[i]) begin
          lock_nxt[i]  = 1'b0;
          own_m_nxt[i] = '0;
          own_p_nxt[i] = '0;
        end
      end
      for (int l = 0; l < LN; l++) begin
        freed_nxt[l] = freed_nxt[l] | free_set;
      end
    end
  end

  // result read from the updated state
  always_comb begin
    rd_lock    = 1'b0;
    rd_m       = '0;
    rd_p       = '0;
    cur_status = '0;
    for (int i = 0; i < SN; i++) begin
      if (hit[i]) begin
        rd_lock = lock_r[i];
        rd_m    = own_m_r[i];
        rd_p    = own_p_r[i];
      end
    end
    for (int l = 0; l < LN; l++) begin
      irq_vec[l] = |(freed_r[l] & en_r[l]);
      if (lsel[l]) cur_status = freed_r[l] & en_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_key_r <= '0;
      lock_r      <= '0;
      for (int i = 0; i < SN; i++) begin
        own_m_r[i] <= '0;
        own_p_r[i] <= '0;
      end
      for (int l = 0; l < LN; l++) begin
        en_r[l]    <= '0;
        freed_r[l] <= '0;
      end
    end else begin
      if (cfg_valid) clear_key_r <= cfg_clear_key;
      lock_r  <= lock_nxt;
      own_m_r <= own_m_nxt;
      own_p_r <= own_p_nxt;
      en_r    <= en_nxt;
      freed_r <= freed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      idx_r  <= in_sem_index;
      mid_r  <= in_master_id;
      pid_r  <= in_process_id;
      key_r  <= in_release_key;
      mask_r <= in_sem_mask[SN-1:0];
      line_r <= in_irq_line;
    end
    success_r <= success_nxt;
    status_r  <= status_nxt;
    if (cmd.respond) begin
      out_success_r       <= success_r;
      out_locked_r        <= rd_lock;
      out_owner_master_r  <= rd_m;
      out_owner_process_r <= rd_p;
      out_masked_status_r <= (op_r == hsb_pkg::OP_SERVICE) ? hsb_pkg::MASK_W'(status_r)
                                                           : hsb_pkg::MASK_W'(cur_status);
      out_irq_out_r       <= hsb_pkg::IRQ_W'(irq_vec);
    end
  end

  assign out_success       = out_success_r;
  assign out_locked        = out_locked_r;
  assign out_owner_master  = out_owner_master_r;
  assign out_owner_process = out_owner_process_r;
  assign out_masked_status = out_masked_status_r;
  assign out_irq_out       = out_irq_out_r;

  a_freed_owner_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == hsb_pkg::OP_RELEASE && success_nxt)
      |=> (|(lock_r & hit)) == 1'b0)
    else $error("successful release left semaphore locked");

  a_release_sets_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (|free_set)) |=> ((freed_r[0] & $past(free_set)) == $past(free_set)))
    else $error("freeing did not raise status flag");

  a_service_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == hsb_pkg::OP_SERVICE)
      |=> ((cur_status & $past(status_nxt)) == '0))
    else $error("service left acknowledged status set");

endmodule

// ----- src/hardware_semaphore_bank.sv -----
`timescale 1ns / 1ps

// Semaphore bank with per-semaphore lock, owner master and owner process, plus
// per-line notification enables and freed flags. Each item runs through a
// three-step controller sequence: capture, execute (state update), respond
// (result register load), which also raises out_valid. The block takes no new
// item until the previous one has passed the respond step. A new item is
// accepted while the previous result still waits at the output register;
// the respond step waits only for that register to free. Release-all, if
// the release key matches, frees every semaphore held by that master in
// the execute cycle. clear_key may be written at any time the block is idle;
// cfg_ready is always high.
module hardware_semaphore_bank #(
  parameter int NUM_SEMAPHORES = hsb_pkg::SEM_DEFAULT,
  parameter int NUM_LINES      = hsb_pkg::LINE_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hsb_pkg::KEY_W-1:0]  cfg_clear_key,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hsb_pkg::OP_W-1:0]   in_operation,
  input  logic [hsb_pkg::IDX_W-1:0]  in_sem_index,
  input  logic [hsb_pkg::MID_W-1:0]  in_master_id,
  input  logic [hsb_pkg::PID_W-1:0]  in_process_id,
  input  logic [hsb_pkg::KEY_W-1:0]  in_release_key,
  input  logic [hsb_pkg::MASK_W-1:0] in_sem_mask,
  input  logic                       in_irq_line,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_success,
  output logic                       out_locked,
  output logic [hsb_pkg::MID_W-1:0]  out_owner_master,
  output logic [hsb_pkg::PID_W-1:0]  out_owner_process,
  output logic [hsb_pkg::MASK_W-1:0] out_masked_status,
  output logic [hsb_pkg::IRQ_W-1:0]  out_irq_out
);

  hsb_pkg::hsb_cmd_t cmd;

  assign cfg_ready = 1'b1;

  hsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  hsb_datapath #(
    .NUM_SEMAPHORES (NUM_SEMAPHORES),
    .NUM_LINES      (NUM_LINES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_valid         (cfg_valid),
    .cfg_clear_key     (cfg_clear_key),
    .in_operation      (in_operation),
    .in_sem_index      (in_sem_index),
    .in_master_id      (in_master_id),
    .in_process_id     (in_process_id),
    .in_release_key    (in_release_key),
    .in_sem_mask       (in_sem_mask),
    .in_irq_line       (in_irq_line),
    .out_success       (out_success),
    .out_locked        (out_locked),
    .out_owner_master  (out_owner_master),
    .out_owner_process (out_owner_process),
    .out_masked_status (out_masked_status),
    .out_irq_out       (out_irq_out)
  );

endmodule
